@@ rtl/fedl_pkg.sv @@
// Shared constants, types and control structures of the feedback echo delay line.
package fedl_pkg;

	localparam int MAX_DELAY  = 32768;
	localparam int ADDR_W     = $clog2(MAX_DELAY);
	localparam int LEN_W      = 16;
	localparam int SAMPLE_W   = 16;
	localparam int DIV_W      = 9;
	localparam int CNT_W      = $clog2(SAMPLE_W);
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [LEN_W-1:0] DELAY_LEN_RST = LEN_W'(MAX_DELAY);
	localparam logic [DIV_W-1:0] FB_DIV_RST    = DIV_W'(2);

	localparam logic [CFG_IDX_W-1:0] REG_DELAY_LEN = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FB_DIV    = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOAD,
		ST_DIV,
		ST_WRITE
	} state_t;

	typedef struct packed {
		logic clr_wr;
		logic capture;
		logic load;
		logic div_step;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic div_last;
	} sts_t;

endpackage

@@ rtl/fedl_ctrl.sv @@
// Sequencing state machine of the feedback echo delay line.
module fedl_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  fedl_pkg::sts_t sts,
	output fedl_pkg::cmd_t cmd
);
	import fedl_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (sts.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_d = ST_LOAD;
			end
			ST_LOAD: begin
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (sts.div_last) state_d = ST_WRITE;
			end
			ST_WRITE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
			end
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
			end
			ST_WRITE: begin
				cmd.commit = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ rtl/fedl_dp.sv @@
// Datapath of the feedback echo delay line: registers, sample memory, divider and adder.
module fedl_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [fedl_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [fedl_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic signed [fedl_pkg::SAMPLE_W-1:0] sample_in,
	output logic signed [fedl_pkg::SAMPLE_W-1:0] sample_out,
	input  fedl_pkg::cmd_t                       cmd,
	output fedl_pkg::sts_t                       sts
);
	import fedl_pkg::*;

	logic [LEN_W-1:0]    delay_len_q;
	logic [DIV_W-1:0]    fb_div_q;
	logic [ADDR_W-1:0]   wp_q;
	logic [ADDR_W-1:0]   clr_addr_q;
	logic [ADDR_W-1:0]   wa_q;
	logic [SAMPLE_W-1:0] rd_q;
	logic [SAMPLE_W-1:0] x_q;
	logic [DIV_W-1:0]    dsor_q;
	logic [DIV_W-1:0]    rem_q;
	logic [SAMPLE_W-1:0] quo_q;
	logic                neg_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [SAMPLE_W-1:0] sample_out_q;

	logic [SAMPLE_W-1:0] mem [MAX_DELAY];

	logic [LEN_W-1:0]           eff_len;
	logic [ADDR_W-1:0]          wp_norm;
	logic [LEN_W-1:0]           rd_next;
	logic [ADDR_W-1:0]          rd_addr;
	logic [LEN_W-1:0]           wa_next;
	logic [DIV_W:0]             trial;
	logic                       qbit;
	logic signed [SAMPLE_W:0]   fb;
	logic signed [SAMPLE_W+1:0] sum;
	logic [SAMPLE_W-1:0]        sat;
	logic                       mem_we;
	logic [ADDR_W-1:0]          mem_wa;
	logic [SAMPLE_W-1:0]        mem_wd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_len_q <= DELAY_LEN_RST;
			fb_div_q    <= FB_DIV_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DELAY_LEN: delay_len_q <= cfg_data;
				REG_FB_DIV:    fb_div_q    <= cfg_data[DIV_W-1:0];
			endcase
		end
	end

	always_comb begin
		if (delay_len_q == '0) begin
			eff_len = LEN_W'(1);
		end else if (delay_len_q > LEN_W'(MAX_DELAY)) begin
			eff_len = LEN_W'(MAX_DELAY);
		end else begin
			eff_len = delay_len_q;
		end
		wp_norm = ({1'b0, wp_q} >= eff_len) ? '0 : wp_q;
		rd_next = {1'b0, wp_norm} + LEN_W'(1);
		rd_addr = (rd_next >= eff_len) ? '0 : rd_next[ADDR_W-1:0];
		wa_next = {1'b0, wa_q} + LEN_W'(1);
	end

	always_comb begin
		trial = {rem_q, quo_q[SAMPLE_W-1]};
		qbit  = trial >= {1'b0, dsor_q};
	end

	always_comb begin
		fb  = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
		sum = $signed({{2{x_q[SAMPLE_W-1]}}, x_q}) + $signed({fb[SAMPLE_W], fb});
		if (sum > $signed((SAMPLE_W+2)'(32767))) begin
			sat = 16'h7fff;
		end else if (sum < -$signed((SAMPLE_W+2)'(32768))) begin
			sat = 16'h8000;
		end else begin
			sat = sum[SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q       <= '0;
			clr_addr_q <= '0;
			cnt_q      <= '0;
		end else begin
			if (cmd.clr_wr) clr_addr_q <= clr_addr_q + ADDR_W'(1);
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cmd.commit) begin
				wp_q <= (wa_next >= eff_len) ? '0 : wa_next[ADDR_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			x_q    <= sample_in;
			wa_q   <= wp_norm;
			dsor_q <= (fb_div_q == '0) ? DIV_W'(1) : fb_div_q;
		end
		if (cmd.load) begin
			neg_q <= rd_q[SAMPLE_W-1];
			quo_q <= rd_q[SAMPLE_W-1] ? -rd_q : rd_q;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= qbit ? DIV_W'(trial - {1'b0, dsor_q}) : trial[DIV_W-1:0];
			quo_q <= {quo_q[SAMPLE_W-2:0], qbit};
		end
		if (cmd.commit) sample_out_q <= sat;
	end

	always_comb begin
		mem_we = cmd.clr_wr || cmd.commit;
		mem_wa = cmd.clr_wr ? clr_addr_q : wa_q;
		mem_wd = cmd.clr_wr ? '0 : sat;
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) rd_q <= mem[rd_addr];
	end

	assign sts.clr_last = &clr_addr_q;
	assign sts.div_last = cnt_q == CNT_W'(SAMPLE_W - 1);
	assign sample_out   = sample_out_q;

endmodule

@@ rtl/feedback_echo_delay_line.sv @@
// Top level of the feedback echo delay line.
// A result beat is offered after its input beat has passed the load, divide and write states.
// A new sample is taken only in idle, once the 16-step bit-serial divider and the write are done.
// After reset all 32768 entries of the sample memory are swept to zero; no input is taken then.
// Configuration writes are taken in every cycle, including during that sweep.
// Reset is asynchronous and active low; control and config registers return to their reset values.
module feedback_echo_delay_line (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [fedl_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [fedl_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [fedl_pkg::SAMPLE_W-1:0] sample_in,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [fedl_pkg::SAMPLE_W-1:0] sample_out
);
	import fedl_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	fedl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	fedl_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.sample_in  (sample_in),
		.sample_out (sample_out),
		.cmd        (cmd),
		.sts        (sts)
	);

	// An accepted beat keeps the block busy for the following cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted while previous sample in flight");

	// A new result appears only as the sequencer returns to idle.
	a_result_at_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result presented outside of idle");

	// A result can never appear in the cycle right after an input beat.
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !$rose(out_valid))
		else $error("result presented too early");

endmodule
